### hdl/uaf_pkg.sv
// Shared types, constants and helpers for the uniaxial anisotropy field block.
// No dependencies; the delay line, the multiplier and the top level import it.
package uaf_pkg;

    // Largest magnitude of a saturated Q47.16 result.
    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

    // 1/mu0 in Q20.16.
    localparam logic signed [63:0] MU0_INV_Q16 = 64'sd52151891752;

    typedef struct packed {
        logic signed [31:0] mag_x;
        logic signed [31:0] mag_y;
        logic signed [31:0] mag_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [31:0] anis_k1;
        logic signed [31:0] anis_k2;
        logic        [47:0] ms_inv;
        logic               last_cell;
    } t_cell_in;

    typedef struct packed {
        logic signed [63:0] field_x;
        logic signed [63:0] field_y;
        logic signed [63:0] field_z;
        logic signed [63:0] energy_density;
        logic               last_out;
    } t_cell_out;

    // Sum of two values in [-SMAX, SMAX], clamped to the same range.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] sum;
        logic signed [64:0] hi;
        sum = $signed({a[63], a}) + $signed({b[63], b});
        hi  = $signed({1'b0, SMAX});
        if (sum > hi) begin
            return SMAX;
        end else if (sum < -hi) begin
            return -SMAX;
        end
        return sum[63:0];
    endfunction

endpackage

### hdl/uniaxial4_anisotropy_field.sv
// Fourth-order uniaxial anisotropy field and energy density, one mesh cell per transfer.
// Depends on uaf_pkg, uaf_delay and uaf_mulsat.
//
// Usage:
// The input channel (i_valid, o_stall, i_cell) takes one mesh cell per transfer:
// magnetization, easy axis, K1, K2, 1/Ms and a last-cell flag. The output channel
// (o_valid, i_stall, o_result) returns one result per cell, in order: the three
// field components and the energy density, all Q47.16 and saturated, plus the
// copied last flag. A cell with 1/Ms of zero yields zero field and zero energy.
// Throughput is one cell per cycle while the receiver does not stall; the fixed-depth
// arithmetic pipeline of four-stage multipliers sets the latency, and no part of it is
// shared between cells.
// When the receiver stalls a valid result, the whole pipeline holds and o_stall is
// raised toward the sender; nothing is dropped or repeated. Bubbles travel with
// their own valid bits. Synchronous active-low reset clears all valid bits; data
// registers are not reset. The block keeps no state between cells.
module uniaxial4_anisotropy_field
    import uaf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_cell_in  i_cell,
    output logic      o_valid,
    input  logic      i_stall,
    output t_cell_out o_result
);

    localparam int LAT = 24;

    logic           en;
    logic [LAT:1]   r_valid;

    // Stage 1: exact products and derived constants.
    logic signed [63:0] r1_pm [3];
    logic signed [63:0] r1_pc [6];
    logic signed [32:0] r1_k1x2, r1_nk1;
    logic signed [33:0] r1_k2x4, r1_k1s;
    logic signed [31:0] r1_k2;
    logic               r1_k1pos, r1_zero, r1_last;
    logic [47:0]        r1_ms;
    logic [95:0]        r1_axis;

    // Stage 2: projection d and cross product components.
    logic signed [65:0] n_dsum;
    logic signed [64:0] n_cr [3];
    logic signed [36:0] r2_d;
    logic signed [35:0] r2_w [3];

    logic signed [36:0] d_l6;
    logic signed [32:0] k1x2_l2, nk1_l6;
    logic signed [33:0] k2x4_l10, k1s_l7;
    logic signed [31:0] k2_l10, k2_l11;
    logic signed [63:0] d2, d3, d4, t1, t2, t1_l14, sc, sc_l15, h;
    logic signed [63:0] sq [3];
    logic signed [63:0] fld [3];
    logic signed [63:0] e1a, e1b, e1a_l15, e1b_l15, e2a, e2a_l15, s2, e2b;
    logic signed [63:0] r7_s, r15_c, r16_e, e_l23;
    logic [95:0]        axis_l19;
    logic               k1pos_l15;
    logic [1:0]         flags_l23;
    logic               r_out_zero;
    t_cell_out          r_out;

    // The pipeline advances unless a finished result is being held.
    assign en      = !r_valid[LAT] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_valid[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[LAT-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pm[0] <= i_cell.mag_x * i_cell.axis_x;
            r1_pm[1] <= i_cell.mag_y * i_cell.axis_y;
            r1_pm[2] <= i_cell.mag_z * i_cell.axis_z;
            r1_pc[0] <= i_cell.axis_y * i_cell.mag_z;
            r1_pc[1] <= i_cell.axis_z * i_cell.mag_y;
            r1_pc[2] <= i_cell.axis_z * i_cell.mag_x;
            r1_pc[3] <= i_cell.axis_x * i_cell.mag_z;
            r1_pc[4] <= i_cell.axis_x * i_cell.mag_y;
            r1_pc[5] <= i_cell.axis_y * i_cell.mag_x;
            r1_k1x2  <= $signed({i_cell.anis_k1, 1'b0});
            r1_nk1   <= -$signed({i_cell.anis_k1[31], i_cell.anis_k1});
            r1_k2x4  <= $signed({i_cell.anis_k2, 2'b00});
            r1_k1s   <= $signed({{2{i_cell.anis_k1[31]}}, i_cell.anis_k1})
                      + $signed({i_cell.anis_k2[31], i_cell.anis_k2, 1'b0});
            r1_k2    <= i_cell.anis_k2;
            r1_k1pos <= !i_cell.anis_k1[31] && (i_cell.anis_k1 != 32'sd0);
            r1_zero  <= (i_cell.ms_inv == 48'd0);
            r1_last  <= i_cell.last_cell;
            r1_ms    <= i_cell.ms_inv;
            r1_axis  <= {i_cell.axis_x, i_cell.axis_y, i_cell.axis_z};
        end
    end

    // Dropping the low 29 bits of the exact sum is the floor of the Q.58 value.
    always_comb begin
        n_dsum = $signed({{2{r1_pm[0][63]}}, r1_pm[0]})
               + $signed({{2{r1_pm[1][63]}}, r1_pm[1]})
               + $signed({{2{r1_pm[2][63]}}, r1_pm[2]});
        n_cr[0] = $signed({r1_pc[0][63], r1_pc[0]}) - $signed({r1_pc[1][63], r1_pc[1]});
        n_cr[1] = $signed({r1_pc[2][63], r1_pc[2]}) - $signed({r1_pc[3][63], r1_pc[3]});
        n_cr[2] = $signed({r1_pc[4][63], r1_pc[4]}) - $signed({r1_pc[5][63], r1_pc[5]});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_d <= n_dsum[65:29];
            for (int i = 0; i < 3; i++) begin
                r2_w[i] <= n_cr[i][64:29];
            end
        end
    end

    // Powers of d.
    uaf_mulsat #(.SHIFT(29)) u_mul_d2 (
        .i_clk(i_clk), .i_en(en),
        .i_a({{27{r2_d[36]}}, r2_d}), .i_b({{27{r2_d[36]}}, r2_d}), .o_p(d2)
    );
    uaf_delay #(.W(37), .N(4)) u_dly_d (.i_clk(i_clk), .i_en(en), .i_d(r2_d), .o_d(d_l6));
    uaf_mulsat #(.SHIFT(29)) u_mul_d3 (
        .i_clk(i_clk), .i_en(en), .i_a(d2), .i_b({{27{d_l6[36]}}, d_l6}), .o_p(d3)
    );
    uaf_mulsat #(.SHIFT(29)) u_mul_d4 (
        .i_clk(i_clk), .i_en(en), .i_a(d2), .i_b(d2), .o_p(d4)
    );

    // Field coefficient c = 2*K1*d + 4*K2*d^3.
    uaf_delay #(.W(33), .N(1)) u_dly_k1x2 (
        .i_clk(i_clk), .i_en(en), .i_d(r1_k1x2), .o_d(k1x2_l2)
    );
    uaf_mulsat #(.SHIFT(13)) u_mul_t1 (
        .i_clk(i_clk), .i_en(en),
        .i_a({{31{k1x2_l2[32]}}, k1x2_l2}), .i_b({{27{r2_d[36]}}, r2_d}), .o_p(t1)
    );
    uaf_delay #(.W(64), .N(8)) u_dly_t1 (.i_clk(i_clk), .i_en(en), .i_d(t1), .o_d(t1_l14));
    uaf_delay #(.W(34), .N(9)) u_dly_k2x4 (
        .i_clk(i_clk), .i_en(en), .i_d(r1_k2x4), .o_d(k2x4_l10)
    );
    uaf_mulsat #(.SHIFT(13)) u_mul_t2 (
        .i_clk(i_clk), .i_en(en),
        .i_a({{30{k2x4_l10[33]}}, k2x4_l10}), .i_b(d3), .o_p(t2)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r15_c <= sat_add(t1_l14, t2);
        end
    end

    // Scale 1/(Ms*mu0) in Q.32.
    uaf_mulsat #(.SHIFT(32)) u_mul_sc (
        .i_clk(i_clk), .i_en(en), .i_a({16'd0, r1_ms}), .i_b(MU0_INV_Q16), .o_p(sc)
    );
    uaf_delay #(.W(64), .N(10)) u_dly_sc (.i_clk(i_clk), .i_en(en), .i_d(sc), .o_d(sc_l15));
    uaf_mulsat #(.SHIFT(32)) u_mul_h (
        .i_clk(i_clk), .i_en(en), .i_a(r15_c), .i_b(sc_l15), .o_p(h)
    );

    // Field along the axis.
    uaf_delay #(.W(96), .N(18)) u_dly_axis (
        .i_clk(i_clk), .i_en(en), .i_d(r1_axis), .o_d(axis_l19)
    );
    for (genvar g = 0; g < 3; g++) begin : g_fld
        logic signed [31:0] ax;
        assign ax = axis_l19[95-32*g -: 32];
        uaf_mulsat #(.SHIFT(29)) u_mul_f (
            .i_clk(i_clk), .i_en(en), .i_a(h), .i_b({{32{ax[31]}}, ax}), .o_p(fld[g])
        );
    end

    // Energy for K1 <= 0: -K1*d^2 - K2*d^4.
    uaf_delay #(.W(33), .N(5)) u_dly_nk1 (.i_clk(i_clk), .i_en(en), .i_d(r1_nk1), .o_d(nk1_l6));
    uaf_mulsat #(.SHIFT(13)) u_mul_e1a (
        .i_clk(i_clk), .i_en(en), .i_a({{31{nk1_l6[32]}}, nk1_l6}), .i_b(d2), .o_p(e1a)
    );
    uaf_delay #(.W(64), .N(5)) u_dly_e1a (.i_clk(i_clk), .i_en(en), .i_d(e1a), .o_d(e1a_l15));
    uaf_delay #(.W(32), .N(9)) u_dly_k2a (.i_clk(i_clk), .i_en(en), .i_d(r1_k2), .o_d(k2_l10));
    uaf_mulsat #(.SHIFT(13)) u_mul_e1b (
        .i_clk(i_clk), .i_en(en), .i_a({{32{k2_l10[31]}}, k2_l10}), .i_b(d4), .o_p(e1b)
    );
    uaf_delay #(.W(64), .N(1)) u_dly_e1b (.i_clk(i_clk), .i_en(en), .i_d(e1b), .o_d(e1b_l15));

    // Energy for K1 > 0: (K1 + 2*K2)*s - K2*s^2 with s = |u x m|^2.
    for (genvar g = 0; g < 3; g++) begin : g_sq
        uaf_mulsat #(.SHIFT(29)) u_mul_sq (
            .i_clk(i_clk), .i_en(en),
            .i_a({{28{r2_w[g][35]}}, r2_w[g]}), .i_b({{28{r2_w[g][35]}}, r2_w[g]}),
            .o_p(sq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_s <= sat_add(sat_add(sq[0], sq[1]), sq[2]);
        end
    end

    uaf_delay #(.W(34), .N(6)) u_dly_k1s (.i_clk(i_clk), .i_en(en), .i_d(r1_k1s), .o_d(k1s_l7));
    uaf_mulsat #(.SHIFT(13)) u_mul_e2a (
        .i_clk(i_clk), .i_en(en), .i_a({{30{k1s_l7[33]}}, k1s_l7}), .i_b(r7_s), .o_p(e2a)
    );
    uaf_delay #(.W(64), .N(4)) u_dly_e2a (.i_clk(i_clk), .i_en(en), .i_d(e2a), .o_d(e2a_l15));
    uaf_mulsat #(.SHIFT(29)) u_mul_s2 (
        .i_clk(i_clk), .i_en(en), .i_a(r7_s), .i_b(r7_s), .o_p(s2)
    );
    uaf_delay #(.W(32), .N(10)) u_dly_k2b (.i_clk(i_clk), .i_en(en), .i_d(r1_k2), .o_d(k2_l11));
    uaf_mulsat #(.SHIFT(13)) u_mul_e2b (
        .i_clk(i_clk), .i_en(en), .i_a({{32{k2_l11[31]}}, k2_l11}), .i_b(s2), .o_p(e2b)
    );

    // The sign of K1 selects which energy form applies.
    uaf_delay #(.W(1), .N(14)) u_dly_k1pos (
        .i_clk(i_clk), .i_en(en), .i_d(r1_k1pos), .o_d(k1pos_l15)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r16_e <= k1pos_l15 ? sat_add(e2a_l15, -e2b) : sat_add(e1a_l15, -e1b_l15);
        end
    end

    uaf_delay #(.W(64), .N(7)) u_dly_e (.i_clk(i_clk), .i_en(en), .i_d(r16_e), .o_d(e_l23));
    uaf_delay #(.W(2), .N(22)) u_dly_flags (
        .i_clk(i_clk), .i_en(en), .i_d({r1_zero, r1_last}), .o_d(flags_l23)
    );

    // Output register; an empty cell forces the field and energy values to zero.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_zero              <= flags_l23[1];
            r_out.last_out          <= flags_l23[0];
            r_out.field_x           <= flags_l23[1] ? 64'sd0 : fld[0];
            r_out.field_y           <= flags_l23[1] ? 64'sd0 : fld[1];
            r_out.field_z           <= flags_l23[1] ? 64'sd0 : fld[2];
            r_out.energy_density    <= flags_l23[1] ? 64'sd0 : e_l23;
        end
    end

    assign o_result = r_out;

    // Saturation is symmetric, so the most negative code never appears.
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.energy_density != SMIN) && (o_result.field_x != SMIN)
                 && (o_result.field_y != SMIN) && (o_result.field_z != SMIN))
        else $error("result holds the most negative code");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_zero) |-> (o_result.energy_density == 64'sd0)
            && (o_result.field_x == 64'sd0) && (o_result.field_y == 64'sd0)
            && (o_result.field_z == 64'sd0))
        else $error("empty cell gave a nonzero result");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_valid[1])
        else $error("accepted cell did not enter the pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_valid))
        else $error("pipeline moved while held");

endmodule

### hdl/uaf_delay.sv
// Enabled shift-register delay line used to align operands across the pipeline.
// Depends on uaf_pkg only through the common import.
module uaf_delay
    import uaf_pkg::*;
#(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_tap [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_d = r_tap[N-1];

endmodule

### hdl/uaf_mulsat.sv
// Four-stage signed multiplier: a*b / 2^SHIFT toward zero, saturated to +-SMAX.
// Built from four 32x32 partial products; depends on uaf_pkg for SMAX.
module uaf_mulsat
    import uaf_pkg::*;
#(
    parameter int SHIFT = 29
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);

    logic [63:0]        r_ma, r_mb;
    logic               r_neg1, r_neg2, r_neg3;
    logic [63:0]        r_p00, r_p01, r_p10, r_p11;
    logic [127:0]       r_prod;
    logic signed [63:0] r_out;
    logic [127:0]       n_q;
    logic [63:0]        n_mag;

    // Magnitudes and sign of the result.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ma   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_mb   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
        end
    end

    // Partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2 <= r_neg1;
            r_p00  <= r_ma[31:0]  * r_mb[31:0];
            r_p01  <= r_ma[31:0]  * r_mb[63:32];
            r_p10  <= r_ma[63:32] * r_mb[31:0];
            r_p11  <= r_ma[63:32] * r_mb[63:32];
        end
    end

    // Full 128-bit product.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg3 <= r_neg2;
            r_prod <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0}
                    + {32'd0, r_p10, 32'd0} + {r_p11, 64'd0};
        end
    end

    // Scale, saturate and restore the sign.
    always_comb begin
        n_q   = r_prod >> SHIFT;
        n_mag = (|n_q[127:63]) ? 64'(SMAX) : {1'b0, n_q[62:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_neg3 ? -$signed(n_mag) : $signed(n_mag);
        end
    end

    assign o_p = r_out;

endmodule
